// ===== design/pcws_pkg.sv =====
`default_nettype none
// ============================================================================
// pcws_pkg: shared types and constants for payload class worker steering
// Holds the controller state encoding, the command and status bundles, and
// the fixed constants used by the classifier and the modulo unit.
// ============================================================================
package pcws_pkg;

    localparam int HASH_W    = 32;
    localparam int STEP_W    = 5;
    localparam int DIV_STEPS = 32;

    // Division by three of a narrow count: multiply by 171 and shift by 9.
    localparam logic [7:0] RECIP3       = 8'd171;
    localparam int         RECIP3_SHIFT = 9;

    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_N = 8'h4E;

    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic accept;
        logic start;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/pcws_if.sv =====
`default_nettype none
// ============================================================================
// pcws_if: channel interfaces for payload class worker steering
// The input channel carries payload bytes with the flow hash; the output
// channel carries one steering decision per packet.
// ============================================================================
interface pcws_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] flow_hash;

    modport source (output valid, output payload_byte, output last_byte,
                    output flow_hash, input ready);
    modport sink   (input valid, input payload_byte, input last_byte,
                    input flow_hash, output ready);
endinterface

interface pcws_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] worker_slot;
    logic       steered;
    logic       is_long_request;

    modport source (output valid, output worker_slot, output steered,
                    output is_long_request, input ready);
    modport sink   (input valid, input worker_slot, input steered,
                    input is_long_request, output ready);
endinterface
`default_nettype wire

// ===== design/pcws_ctrl.sv =====
`default_nettype none
// ============================================================================
// pcws_ctrl: sequencer for payload class worker steering
// Accepts bytes, runs the modulo unit after the last byte, then hands the
// result to the output register.
// ============================================================================
module pcws_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    input  pcws_pkg::t_sts     i_sts,
    output pcws_pkg::t_cmd     o_cmd
);

    pcws_pkg::t_state r_state;
    pcws_pkg::t_state n_state;
    logic             accept;

    assign o_in_ready = (r_state == pcws_pkg::S_RUN);
    assign accept     = i_in_valid & o_in_ready;

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.start    = accept & i_in_last;
        o_cmd.div_step = (r_state == pcws_pkg::S_DIV);
        o_cmd.load_out = (r_state == pcws_pkg::S_DONE) & i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcws_pkg::S_RUN: begin
                if (accept && i_in_last) n_state = pcws_pkg::S_DIV;
            end
            pcws_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = pcws_pkg::S_DONE;
            end
            pcws_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = pcws_pkg::S_RUN;
            end
            default: n_state = pcws_pkg::S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcws_pkg::S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded while output register is occupied");

    a_start_enters_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == pcws_pkg::S_DIV))
        else $error("last byte did not start the modulo unit");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcws_pkg::S_DIV && !i_sts.div_last) |=> (r_state == pcws_pkg::S_DIV))
        else $error("modulo unit left before its final step");
`endif

endmodule
`default_nettype wire

// ===== design/pcws_dp.sv =====
`default_nettype none
// ============================================================================
// pcws_dp: datapath for payload class worker steering
// Byte window classifier, worker count register, bit-serial modulo unit and
// the output register.
// ============================================================================
module pcws_dp #(
    parameter int MAX_WORKERS  = 128,
    parameter int SCAN_WINDOWS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_wdata,
    input  wire logic [7:0]    i_payload_byte,
    input  wire logic [31:0]   i_flow_hash,
    input  pcws_pkg::t_cmd     i_cmd,
    output pcws_pkg::t_sts     o_sts,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output logic [6:0]         o_worker_slot,
    output logic               o_steered,
    output logic               o_is_long_request
);

    localparam int CW = $clog2(MAX_WORKERS + 1);
    localparam int PW = $clog2(SCAN_WINDOWS + 4);
    localparam int MW = CW + 8;
    localparam logic [PW-1:0] POS_END = PW'(SCAN_WINDOWS + 3);

    logic [7:0]                  r_active_workers;
    logic [23:0]                 r_recent;
    logic [PW-1:0]               r_pos;
    logic                        r_decided;
    logic                        r_is_scan;

    logic [CW-1:0]               r_count;
    logic                        r_scan_cls;
    logic [CW-1:0]               r_divisor;
    logic [CW-1:0]               r_base;
    logic [pcws_pkg::HASH_W-1:0] r_dividend;
    logic [CW-1:0]               r_rem;
    logic [pcws_pkg::STEP_W-1:0] r_step;

    logic                        r_out_valid;
    logic [6:0]                  r_slot;
    logic                        r_steered;
    logic                        r_long;

    logic [7:0]    c0, c1, c2;
    logic          win_ok, get_hit, scan_hit;
    logic          n_decided, n_is_scan;
    logic [CW-1:0] count;
    logic [MW-1:0] prod3;
    logic [CW-1:0] sw;
    logic [CW-1:0] n_divisor, n_base;
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_sub;
    logic [CW-1:0] slot;

    // Window classifier.
    assign c0 = r_recent[23:16];
    assign c1 = r_recent[15:8];
    assign c2 = r_recent[7:0];

    assign win_ok   = !r_decided && (r_pos >= PW'(3)) && (r_pos != POS_END);
    assign get_hit  = (c0 == pcws_pkg::CH_G) && (c1 == pcws_pkg::CH_E) &&
                      (c2 == pcws_pkg::CH_T);
    assign scan_hit = (c0 == pcws_pkg::CH_S) && (c1 == pcws_pkg::CH_C) &&
                      (c2 == pcws_pkg::CH_A) && (i_payload_byte == pcws_pkg::CH_N);

    always_comb begin
        n_decided = r_decided;
        n_is_scan = r_is_scan;
        if (win_ok && get_hit) begin
            n_decided = 1'b1;
            n_is_scan = 1'b0;
        end else if (win_ok && scan_hit) begin
            n_decided = 1'b1;
            n_is_scan = 1'b1;
        end
    end

    // Clamped worker count and the divisor and base for this packet's class.
    always_comb begin
        if ({1'b0, r_active_workers} > 9'(MAX_WORKERS)) begin
            count = CW'(MAX_WORKERS);
        end else begin
            count = CW'(r_active_workers);
        end
        prod3 = MW'(count) * MW'(pcws_pkg::RECIP3);
        sw    = CW'(prod3 >> pcws_pkg::RECIP3_SHIFT);
        if (sw == '0) sw = CW'(1);
        if (sw >= count) sw = count - CW'(1);
        if (count <= CW'(1)) begin
            n_divisor = CW'(1);
            n_base    = '0;
        end else if (n_decided && n_is_scan) begin
            n_divisor = sw;
            n_base    = count - sw;
        end else begin
            n_divisor = count;
            n_base    = '0;
        end
    end

    // One restoring division step per cycle.
    assign rem_sh  = {r_rem, r_dividend[pcws_pkg::HASH_W-1]};
    assign rem_sub = rem_sh - (CW+1)'(r_divisor);
    assign slot    = (r_count <= CW'(1)) ? '0 : r_base + r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_workers <= '0;
        end else if (i_cfg_we) begin
            r_active_workers <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent  <= '0;
            r_pos     <= '0;
            r_decided <= 1'b0;
            r_is_scan <= 1'b0;
        end else if (i_cmd.start) begin
            r_recent  <= '0;
            r_pos     <= '0;
            r_decided <= 1'b0;
            r_is_scan <= 1'b0;
        end else if (i_cmd.accept) begin
            r_recent  <= {r_recent[15:0], i_payload_byte};
            if (r_pos != POS_END) r_pos <= r_pos + PW'(1);
            r_decided <= n_decided;
            r_is_scan <= n_is_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.start) begin
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + pcws_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_count    <= count;
            r_scan_cls <= n_decided && n_is_scan;
            r_divisor  <= n_divisor;
            r_base     <= n_base;
            r_dividend <= i_flow_hash;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= r_dividend << 1;
            if (rem_sh >= (CW+1)'(r_divisor)) begin
                r_rem <= CW'(rem_sub);
            end else begin
                r_rem <= CW'(rem_sh);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_slot    <= 7'(slot);
            r_steered <= (r_count != '0);
            r_long    <= r_scan_cls;
        end
    end

    always_comb begin
        o_sts.div_last = (r_step == pcws_pkg::STEP_W'(pcws_pkg::DIV_STEPS - 1));
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_worker_slot     = r_slot;
    assign o_steered         = r_steered;
    assign o_is_long_request = r_long;

endmodule
`default_nettype wire

// ===== design/payload_class_worker_steering_top.sv =====
`default_nettype none
// ============================================================================
// payload_class_worker_steering_top: payload class worker steering
// Classifies each packet as a short (GET) or long (SCAN) request from its
// leading payload bytes and picks a worker slot from the flow hash.
// ============================================================================
//
//  Channel   Dir  Fields                                   Transfer
//  --------  ---  ---------------------------------------  ------------------
//  i_in      in   payload_byte, last_byte, flow_hash       valid & ready
//  o_out     out  worker_slot, steered, is_long_request    valid & ready
//  cfg       in   i_cfg_wdata (active_workers)             i_cfg_we
//
//  Payload bytes transfer at one per cycle while the input is ready. After
//  the last byte the input stalls while the bit-serial hash modulo runs and
//  then while the result is handed to the output register. A result still
//  waiting in the output register does not block the next packet's bytes,
//  its last byte included; after that packet's modulo the input stays
//  stalled until the output register frees up.
//  Reset is synchronous and active low and clears the worker count to zero.
//
module payload_class_worker_steering_top #(
    parameter int MAX_WORKERS  = 128,
    parameter int SCAN_WINDOWS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    pcws_in_if.sink         i_in,
    pcws_out_if.source      o_out
);

    // Command and status bundles between the sequencer and the datapath.
    pcws_pkg::t_cmd cmd;
    pcws_pkg::t_sts sts;
    logic           in_ready;

    // The sequencer owns the input handshake: bytes are taken only while it
    // is in its run state.
    pcws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_byte),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // The datapath holds the classifier window, the modulo unit and the
    // output register that drives the result channel.
    pcws_dp #(
        .MAX_WORKERS  (MAX_WORKERS),
        .SCAN_WINDOWS (SCAN_WINDOWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_payload_byte    (i_in.payload_byte),
        .i_flow_hash       (i_in.flow_hash),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_worker_slot     (o_out.worker_slot),
        .o_steered         (o_out.steered),
        .o_is_long_request (o_out.is_long_request)
    );

endmodule
`default_nettype wire
